FILE: sv/pbt_pkg.sv
// Shared constants, codes and control types for the port binding table.
package pbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int HANDLE_BITS_DEF   = 10;

    localparam int OP_W     = 2;
    localparam int PORT_W   = 16;
    localparam int PROTO_W  = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_BIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNBIND = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [PROTO_W-1:0] PROTO_ANY  = 2'd0;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 2'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 2'd2;
    localparam logic [PROTO_W-1:0] PROTO_RSVD = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IN_USE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic clr_wr;
        logic decide;
        logic wr_first;
        logic wr_second;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic wr1;
        logic wr2;
    } sts_t;

endpackage

FILE: sv/pbt_req_if.sv
// Request channel: operation, port, protocol and owner handle.
interface pbt_req_if #(
    parameter int HANDLE_BITS = pbt_pkg::HANDLE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [pbt_pkg::OP_W-1:0]    operation;
    logic [pbt_pkg::PORT_W-1:0]  port_number;
    logic [pbt_pkg::PROTO_W-1:0] protocol;
    logic [HANDLE_BITS-1:0]      owner_handle;

    modport source (output valid, operation, port_number, protocol, owner_handle,
                    input ready);
    modport sink   (input valid, operation, port_number, protocol, owner_handle,
                    output ready);
endinterface

FILE: sv/pbt_rsp_if.sv
// Response channel: status, matched handle and matched protocol.
interface pbt_rsp_if #(
    parameter int HANDLE_BITS = pbt_pkg::HANDLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [pbt_pkg::STATUS_W-1:0] status;
    logic [HANDLE_BITS-1:0]       found_handle;
    logic [pbt_pkg::PROTO_W-1:0]  found_protocol;

    modport source (output valid, status, found_handle, found_protocol, input ready);
    modport sink   (input valid, status, found_handle, found_protocol, output ready);
endinterface

FILE: sv/pbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/pbt_ctrl.sv
// Controller: clearing pass, table scan, decision, write-back and output sequencing.
module pbt_ctrl #(
    parameter int TABLE_ENTRIES = pbt_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    input  pbt_pkg::sts_t       sts,
    output pbt_pkg::cmd_t       cmd,
    output logic [IDX_W-1:0]    idx
);
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LAST   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_WR1    = 3'd5;
    localparam logic [2:0] S_WR2    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             last;

    assign last = (cnt_reg == LAST_IDX);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (last)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                cmd.wr_first = sts.wr1;
                state_next   = sts.wr2 ? S_WR2 : S_DONE;
            end
            S_WR2:
            begin
                cmd.wr_second = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg & ~rsp_ready) | cmd.out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign idx       = cnt_reg;
endmodule

FILE: sv/pbt_dp.sv
// Datapath: request capture, scan accumulation, result decision and table writes.
module pbt_dp #(
    parameter int TABLE_ENTRIES = pbt_pkg::TABLE_ENTRIES_DEF,
    parameter int HANDLE_BITS   = pbt_pkg::HANDLE_BITS_DEF,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES),
    localparam int WORD_W       = 2 + pbt_pkg::PORT_W + pbt_pkg::PROTO_W + HANDLE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pbt_pkg::cmd_t                cmd,
    input  logic [IDX_W-1:0]             idx,
    output pbt_pkg::sts_t                sts,
    input  logic [pbt_pkg::OP_W-1:0]     operation,
    input  logic [pbt_pkg::PORT_W-1:0]   port_number,
    input  logic [pbt_pkg::PROTO_W-1:0]  protocol,
    input  logic [HANDLE_BITS-1:0]       owner_handle,
    output logic [pbt_pkg::STATUS_W-1:0] status,
    output logic [HANDLE_BITS-1:0]       found_handle,
    output logic [pbt_pkg::PROTO_W-1:0]  found_protocol,
    output logic                         ram_we,
    output logic [IDX_W-1:0]             ram_waddr,
    output logic [WORD_W-1:0]            ram_wdata,
    output logic                         ram_re,
    output logic [IDX_W-1:0]             ram_raddr,
    input  logic [WORD_W-1:0]            ram_rdata
);
    localparam int PW        = pbt_pkg::PORT_W;
    localparam int RW        = pbt_pkg::PROTO_W;
    localparam int PROTO_LO  = HANDLE_BITS;
    localparam int PORT_LO   = PROTO_LO + RW;
    localparam int LATER_BIT = PORT_LO + PW;
    localparam int VALID_BIT = LATER_BIT + 1;

    // Request captured at transfer.
    logic [pbt_pkg::OP_W-1:0] op_reg;
    logic [PW-1:0]            port_reg;
    logic [RW-1:0]            proto_reg;
    logic [HANDLE_BITS-1:0]   owner_reg;

    // Read pipeline and scan accumulators: up to two entries share a port.
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   a_found_reg, b_found_reg, free_found_reg;
    logic [IDX_W-1:0]       a_idx_reg, b_idx_reg, free_idx_reg;
    logic                   a_later_reg, b_later_reg;
    logic [RW-1:0]          a_proto_reg, b_proto_reg;
    logic [HANDLE_BITS-1:0] a_owner_reg, b_owner_reg;

    // Decision results and planned writes.
    logic [pbt_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [HANDLE_BITS-1:0]       res_handle_reg, res_handle_next;
    logic [RW-1:0]                res_proto_reg, res_proto_next;
    logic                         wr1_reg, wr1_next, wr2_reg, wr2_next;
    logic [IDX_W-1:0]             wr1_addr_reg, wr1_addr_next, wr2_addr_reg, wr2_addr_next;
    logic [WORD_W-1:0]            wr1_data_reg, wr1_data_next, wr2_data_reg, wr2_data_next;

    logic [pbt_pkg::STATUS_W-1:0] out_status_reg;
    logic [HANDLE_BITS-1:0]       out_handle_reg;
    logic [RW-1:0]                out_proto_reg;

    logic        e_valid, e_later, e_port_hit;
    logic [RW-1:0] e_proto;
    logic        ma, mb, sel_b, hit;
    logic [RW-1:0] in_proto;

    function automatic logic proto_match(input logic [pbt_pkg::OP_W-1:0] op,
                                         input logic [RW-1:0] want,
                                         input logic [RW-1:0] have);
        logic r;
        r = 1'b0;
        case (op)
            pbt_pkg::OP_BIND:
                r = (want == pbt_pkg::PROTO_ANY) || (have == pbt_pkg::PROTO_ANY) ||
                    (have == want);
            pbt_pkg::OP_UNBIND:
                r = (have == want);
            pbt_pkg::OP_LOOKUP:
                r = (want == pbt_pkg::PROTO_ANY) || (have == want);
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

    assign in_proto = (protocol == pbt_pkg::PROTO_RSVD) ? pbt_pkg::PROTO_ANY : protocol;

    assign e_valid    = ram_rdata[VALID_BIT];
    assign e_later    = ram_rdata[LATER_BIT];
    assign e_port_hit = (ram_rdata[PORT_LO +: PW] == port_reg);
    assign e_proto    = ram_rdata[PROTO_LO +: RW];

    assign ma    = a_found_reg && proto_match(op_reg, proto_reg, a_proto_reg);
    assign mb    = b_found_reg && proto_match(op_reg, proto_reg, b_proto_reg);
    assign sel_b = mb && (!ma || (a_later_reg && !b_later_reg));
    assign hit   = ma || mb;

    always_comb
    begin
        res_status_next = pbt_pkg::ST_OK;
        res_handle_next = '0;
        res_proto_next  = '0;
        wr1_next        = 1'b0;
        wr2_next        = 1'b0;
        wr1_addr_next   = sel_b ? b_idx_reg : a_idx_reg;
        wr2_addr_next   = sel_b ? a_idx_reg : b_idx_reg;
        wr1_data_next   = '0;
        wr2_data_next   = {1'b1, 1'b0, port_reg,
                           sel_b ? a_proto_reg : b_proto_reg,
                           sel_b ? a_owner_reg : b_owner_reg};
        case (op_reg)
            pbt_pkg::OP_BIND:
            begin
                if (hit)
                begin
                    res_status_next = pbt_pkg::ST_IN_USE;
                    res_handle_next = sel_b ? b_owner_reg : a_owner_reg;
                    res_proto_next  = sel_b ? b_proto_reg : a_proto_reg;
                end
                else if (!free_found_reg)
                begin
                    res_status_next = pbt_pkg::ST_FULL;
                end
                else
                begin
                    wr1_next      = 1'b1;
                    wr1_addr_next = free_idx_reg;
                    wr1_data_next = {1'b1, a_found_reg, port_reg, proto_reg, owner_reg};
                end
            end
            pbt_pkg::OP_UNBIND:
            begin
                if (hit)
                begin
                    res_handle_next = sel_b ? b_owner_reg : a_owner_reg;
                    res_proto_next  = sel_b ? b_proto_reg : a_proto_reg;
                    wr1_next        = 1'b1;
                    wr2_next        = sel_b ? a_found_reg : b_found_reg;
                end
                else
                begin
                    res_status_next = pbt_pkg::ST_NOT_FOUND;
                end
            end
            pbt_pkg::OP_LOOKUP:
            begin
                if (hit)
                begin
                    res_handle_next = sel_b ? b_owner_reg : a_owner_reg;
                    res_proto_next  = sel_b ? b_proto_reg : a_proto_reg;
                end
                else
                begin
                    res_status_next = pbt_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                res_status_next = pbt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg     <= 1'b0;
            a_found_reg    <= 1'b0;
            b_found_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            wr1_reg        <= 1'b0;
            wr2_reg        <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                a_found_reg    <= 1'b0;
                b_found_reg    <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (rd_vld_reg)
            begin
                if (!e_valid)
                begin
                    if (!free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
                else if (e_port_hit)
                begin
                    if (!a_found_reg)
                    begin
                        a_found_reg <= 1'b1;
                    end
                    else if (!b_found_reg)
                    begin
                        b_found_reg <= 1'b1;
                    end
                end
            end
            if (cmd.decide)
            begin
                wr1_reg <= wr1_next;
                wr2_reg <= wr2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx;
        if (cmd.load)
        begin
            op_reg    <= operation;
            port_reg  <= port_number;
            proto_reg <= in_proto;
            owner_reg <= owner_handle;
        end
        if (rd_vld_reg && !cmd.load)
        begin
            if (!e_valid && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if (e_valid && e_port_hit && !a_found_reg)
            begin
                a_idx_reg   <= rd_idx_reg;
                a_later_reg <= e_later;
                a_proto_reg <= e_proto;
                a_owner_reg <= ram_rdata[HANDLE_BITS-1:0];
            end
            if (e_valid && e_port_hit && a_found_reg && !b_found_reg)
            begin
                b_idx_reg   <= rd_idx_reg;
                b_later_reg <= e_later;
                b_proto_reg <= e_proto;
                b_owner_reg <= ram_rdata[HANDLE_BITS-1:0];
            end
        end
        if (cmd.decide)
        begin
            res_status_reg <= res_status_next;
            res_handle_reg <= res_handle_next;
            res_proto_reg  <= res_proto_next;
            wr1_addr_reg   <= wr1_addr_next;
            wr1_data_reg   <= wr1_data_next;
            wr2_addr_reg   <= wr2_addr_next;
            wr2_data_reg   <= wr2_data_next;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_proto_reg  <= res_proto_reg;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx;
        ram_wdata = '0;
        if (cmd.clr_wr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.wr_first)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr1_addr_reg;
            ram_wdata = wr1_data_reg;
        end
        else if (cmd.wr_second)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr2_addr_reg;
            ram_wdata = wr2_data_reg;
        end
    end

    assign ram_re    = cmd.rd_en;
    assign ram_raddr = idx;

    assign sts.wr1 = wr1_reg;
    assign sts.wr2 = wr2_reg;

    assign status         = out_status_reg;
    assign found_handle   = out_handle_reg;
    assign found_protocol = out_proto_reg;
endmodule

FILE: sv/port_binding_table.sv
// Top level of the port binding table: controller, datapath and entry RAM.
//
// A request on req carries an operation (bind, unbind, lookup), a port
// number, a protocol (any, UDP, TCP) and an owner handle. Each request
// yields exactly one response on rsp with a status, the matched owner
// handle and the matched protocol.
// Requests are handled one at a time. Each one scans every table entry
// through the single read port of the entry RAM, one entry per cycle, and
// then applies up to two writes. The response becomes valid once the
// scan, the decision and the writes are done, and req is ready again in
// the same cycle, so a new request is taken only after the previous
// result has been loaded into the output register.
// After reset the block writes every entry invalid, one per cycle, and req
// is not ready until every entry is cleared. The response sits in an output
// register; a new request may be taken while it waits, and when the
// receiver stalls, the next result is held until the register is free.
module port_binding_table #(
    parameter int TABLE_ENTRIES = pbt_pkg::TABLE_ENTRIES_DEF,
    parameter int HANDLE_BITS   = pbt_pkg::HANDLE_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    pbt_req_if.sink  req,
    pbt_rsp_if.source rsp
);
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = 2 + pbt_pkg::PORT_W + pbt_pkg::PROTO_W + HANDLE_BITS;

    pbt_pkg::cmd_t     cmd;
    pbt_pkg::sts_t     sts;
    logic [IDX_W-1:0]  idx;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    pbt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .sts       (sts),
        .cmd       (cmd),
        .idx       (idx)
    );

    pbt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HANDLE_BITS   (HANDLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .idx            (idx),
        .sts            (sts),
        .operation      (req.operation),
        .port_number    (req.port_number),
        .protocol       (req.protocol),
        .owner_handle   (req.owner_handle),
        .status         (rsp.status),
        .found_handle   (rsp.found_handle),
        .found_protocol (rsp.found_protocol),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    pbt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

FILE: sv/pbt_checker.sv
// Port-level checker for the port binding table and its bind statement.
module pbt_checker #(
    parameter int HANDLE_BITS = pbt_pkg::HANDLE_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [pbt_pkg::STATUS_W-1:0] status,
    input logic [HANDLE_BITS-1:0]       found_handle,
    input logic [pbt_pkg::PROTO_W-1:0]  found_protocol
);
    // A stalled response stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(status) && $stable(found_handle) &&
                                    $stable(found_protocol))
        else $error("response payload changed while stalled");

    // Requests are serviced one at a time, so ready drops after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is in progress");

    // A full table or a missing entry reports no handle and no protocol.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == pbt_pkg::ST_FULL || status == pbt_pkg::ST_NOT_FOUND)
        |-> found_handle == '0 && found_protocol == '0)
        else $error("nonzero result fields with a failing status");

    // No response can become valid right after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("response appeared too early");
endmodule

bind port_binding_table pbt_checker #(
    .HANDLE_BITS (HANDLE_BITS)
) u_pbt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .found_handle   (rsp.found_handle),
    .found_protocol (rsp.found_protocol)
);

FILE: tb/sv/tb_port_binding_table.sv
// Self-checking testbench for the port binding table: random and directed requests.
`timescale 1ns / 100ps

module tb_port_binding_table;

    import pbt_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int HANDLE_BITS   = HANDLE_BITS_DEF;
    localparam int POOL_SIZE     = 48;
    localparam int RANDOM_ITEMS  = 1880;
    localparam int IDLE_PCT      = 34;
    localparam int CALM_FROM     = 900;
    localparam int CALM_TO       = 1100;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 320;
    localparam int MAX_REPORTS   = 40;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef enum logic [1:0] {MATCH_EXACT, MATCH_PORT, MATCH_CLASH} match_e;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [PORT_W-1:0]      port;
        logic [PROTO_W-1:0]     proto;
        logic [HANDLE_BITS-1:0] owner;
    } bind_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [HANDLE_BITS-1:0] handle;
        logic [PROTO_W-1:0]     proto;
    } bind_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    pbt_req_if #(.HANDLE_BITS(HANDLE_BITS)) req_ch ();
    pbt_rsp_if #(.HANDLE_BITS(HANDLE_BITS)) rsp_ch ();

    port_binding_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .HANDLE_BITS  (HANDLE_BITS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    logic                   tab_valid [0:TABLE_ENTRIES-1];
    logic [PORT_W-1:0]      tab_port  [0:TABLE_ENTRIES-1];
    logic [PROTO_W-1:0]     tab_proto [0:TABLE_ENTRIES-1];
    logic [HANDLE_BITS-1:0] tab_owner [0:TABLE_ENTRIES-1];
    logic                   tab_later [0:TABLE_ENTRIES-1];

    bind_req_t req_backlog[$];
    bind_rsp_t rsp_expected[$];
    bind_req_t req_live;
    logic [PORT_W-1:0] port_pool [0:POOL_SIZE-1];

    int pushed_cnt = 0;
    int sent_cnt   = 0;
    int rcvd_cnt   = 0;
    int err_cnt    = 0;
    int hold_left  = 0;
    int hold_done  = 0;
    int op_stat [0:3][0:3];

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int find_slot(input logic [PORT_W-1:0] port,
                                     input logic [PROTO_W-1:0] proto, input match_e how);
        int  hit;
        logic ok;
        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tab_valid[i] && tab_port[i] == port) begin
                case (how)
                    MATCH_EXACT: ok = (tab_proto[i] == proto);
                    MATCH_PORT:  ok = 1'b1;
                    default:     ok = (proto == PROTO_ANY) || (tab_proto[i] == PROTO_ANY) ||
                                      (tab_proto[i] == proto);
                endcase
                if (ok && (hit < 0 || (tab_later[hit] && !tab_later[i])))
                    hit = i;
            end
        end
        return hit;
    endfunction

    function automatic bind_rsp_t table_apply(input bind_req_t rq);
        bind_rsp_t          r;
        logic [PROTO_W-1:0] pr;
        int                 k;
        int                 slot;
        r = '0;
        pr = (rq.proto == PROTO_RSVD) ? PROTO_ANY : rq.proto;
        case (rq.op)
            OP_BIND:
            begin
                k = find_slot(rq.port, pr, MATCH_CLASH);
                if (k >= 0)
                begin
                    r.status = ST_IN_USE;
                    r.handle = tab_owner[k];
                    r.proto  = tab_proto[k];
                end
                else
                begin
                    slot = -1;
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                        if (!tab_valid[i])
                            slot = i;
                    if (slot < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        tab_later[slot] = (find_slot(rq.port, pr, MATCH_PORT) >= 0);
                        tab_valid[slot] = 1'b1;
                        tab_port[slot]  = rq.port;
                        tab_proto[slot] = pr;
                        tab_owner[slot] = rq.owner;
                    end
                end
            end
            OP_UNBIND:
            begin
                k = find_slot(rq.port, pr, MATCH_EXACT);
                if (k < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.handle = tab_owner[k];
                    r.proto  = tab_proto[k];
                    tab_valid[k] = 1'b0;
                    tab_later[k] = 1'b0;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (tab_valid[i] && tab_port[i] == rq.port)
                            tab_later[i] = 1'b0;
                end
            end
            OP_LOOKUP:
            begin
                if (pr == PROTO_ANY)
                    k = find_slot(rq.port, pr, MATCH_PORT);
                else
                    k = find_slot(rq.port, pr, MATCH_EXACT);
                if (k < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.handle = tab_owner[k];
                    r.proto  = tab_proto[k];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive_req
        bind_rsp_t want;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                tab_valid[i] = 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                want = table_apply(req_live);
                rsp_expected.push_back(want);
                op_stat[req_live.op][want.status]++;
                sent_cnt++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_backlog.size() > 0 &&
                    ((sent_cnt >= CALM_FROM && sent_cnt < CALM_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    req_live = req_backlog.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.operation    <= req_live.op;
                    req_ch.port_number  <= req_live.port;
                    req_ch.protocol     <= req_live.proto;
                    req_ch.owner_handle <= req_live.owner;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_rsp
        bind_rsp_t seen;
        bind_rsp_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen.status = rsp_ch.status;
                seen.handle = rsp_ch.found_handle;
                seen.proto  = rsp_ch.found_protocol;
                if (rsp_expected.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected transfer, expected none,", $time,
                                 " actual status %0d handle %0d protocol %0d",
                                 seen.status, seen.handle, seen.proto);
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    if (seen !== want)
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: mismatch, expected status %0d handle %0d",
                                     $time, want.status, want.handle,
                                     " protocol %0d, actual status %0d handle %0d",
                                     want.proto, seen.status, seen.handle,
                                     " protocol %0d", seen.proto);
                    end
                end
                rcvd_cnt++;
            end
            if (!hold_done && rcvd_cnt >= HOLD_AT && req_backlog.size() > 20)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rcvd_cnt >= CALM_FROM && rcvd_cnt < CALM_TO)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic queue_req(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                             input logic [PROTO_W-1:0] proto,
                             input logic [HANDLE_BITS-1:0] owner);
        bind_req_t rq;
        rq.op    = op;
        rq.port  = port;
        rq.proto = proto;
        rq.owner = owner;
        req_backlog.push_back(rq);
        pushed_cnt++;
    endtask

    task automatic wait_for_drain();
        while (rcvd_cnt < pushed_cnt)
            @(posedge clk);
    endtask

    task automatic queue_random(input int n_ports, input int w_bind, input int w_unbind);
        int unsigned        pick;
        logic [OP_W-1:0]    op;
        logic [PORT_W-1:0]  port;
        pick = $urandom_range(0, 99);
        if (pick < w_bind)
            op = OP_BIND;
        else if (pick < w_bind + w_unbind)
            op = OP_UNBIND;
        else if (pick < 96)
            op = OP_LOOKUP;
        else
            op = OP_NONE;
        if ($urandom_range(0, 11) == 0)
            port = PORT_W'($urandom);
        else
            port = port_pool[$urandom_range(0, n_ports - 1)];
        queue_req(op, port, PROTO_W'($urandom_range(0, 3)), HANDLE_BITS'($urandom));
    endtask

    initial
    begin : stimulus
        int rand_cnt;
        int seg_len;
        int kind;
        logic [PROTO_W-1:0] pr;
        rst_n = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = '0;
        req_ch.port_number  = '0;
        req_ch.protocol     = '0;
        req_ch.owner_handle = '0;
        rsp_ch.ready        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        queue_req(OP_LOOKUP, 16'd0, PROTO_ANY, 10'd0);
        queue_req(OP_UNBIND, 16'd0, PROTO_UDP, 10'd0);
        queue_req(OP_BIND,   16'd0, PROTO_UDP, 10'd0);
        queue_req(OP_BIND,   16'd0, PROTO_UDP, 10'd1023);
        queue_req(OP_BIND,   16'd0, PROTO_RSVD, 10'd77);
        queue_req(OP_UNBIND, 16'd0, PROTO_ANY, 10'd0);
        queue_req(OP_BIND,   16'd0, PROTO_TCP, 10'd1023);
        queue_req(OP_LOOKUP, 16'd0, PROTO_ANY, 10'd0);
        queue_req(OP_LOOKUP, 16'd0, PROTO_TCP, 10'd0);
        queue_req(OP_UNBIND, 16'd0, PROTO_UDP, 10'd0);
        queue_req(OP_LOOKUP, 16'd0, PROTO_RSVD, 10'd0);
        queue_req(OP_BIND,   16'hFFFF, PROTO_RSVD, 10'd1023);
        queue_req(OP_BIND,   16'hFFFF, PROTO_TCP, 10'd1);
        queue_req(OP_LOOKUP, 16'hFFFF, PROTO_UDP, 10'd0);
        queue_req(OP_LOOKUP, 16'hFFFF, PROTO_ANY, 10'd0);
        queue_req(OP_UNBIND, 16'hFFFF, PROTO_RSVD, 10'd0);
        queue_req(OP_NONE,   16'hA5C3, PROTO_TCP, 10'd512);
        queue_req(OP_NONE,   16'h5A3C, PROTO_RSVD, 10'd511);
        queue_req(OP_UNBIND, 16'd0, PROTO_TCP, 10'd0);
        queue_req(OP_BIND,   16'd0, PROTO_TCP, 10'd3);
        queue_req(OP_BIND,   16'd0, PROTO_UDP, 10'd4);
        queue_req(OP_UNBIND, 16'd0, PROTO_TCP, 10'd0);
        queue_req(OP_BIND,   16'd0, PROTO_TCP, 10'd6);
        queue_req(OP_LOOKUP, 16'd0, PROTO_ANY, 10'd0);

        rand_cnt = 0;
        while (rand_cnt < RANDOM_ITEMS)
        begin
            wait_for_drain();
            if (rand_cnt == 0 || $urandom_range(0, 2) == 0)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (tab_valid[i])
                    begin
                        pr = tab_proto[i];
                        if (pr == PROTO_ANY && $urandom_range(0, 1) == 1)
                            pr = PROTO_RSVD;
                        queue_req(OP_UNBIND, tab_port[i], pr, HANDLE_BITS'($urandom));
                        rand_cnt++;
                    end
                end
                for (int i = 0; i < POOL_SIZE; i++)
                begin
                    case ($urandom_range(0, 15))
                        0:       port_pool[i] = 16'd0;
                        1:       port_pool[i] = 16'hFFFF;
                        default: port_pool[i] = PORT_W'($urandom);
                    endcase
                end
            end
            kind = $urandom_range(0, 2);
            seg_len = $urandom_range(60, 160);
            repeat (seg_len)
            begin
                case (kind)
                    0:       queue_random($urandom_range(2, 8), 40, 25);
                    1:       queue_random($urandom_range(20, POOL_SIZE), 70, 10);
                    default: queue_random($urandom_range(8, 24), 35, 30);
                endcase
                rand_cnt++;
            end
        end

        wait_for_drain();
        repeat (3 * TABLE_ENTRIES) @(posedge clk);
        if (rsp_expected.size() != 0)
        begin
            err_cnt++;
            $display("%0t: %0d expected transfers never arrived", $time, rsp_expected.size());
        end

        $display("Covered %0d requests: binds ok/in use/full %0d/%0d/%0d,",
                 sent_cnt, op_stat[OP_BIND][ST_OK], op_stat[OP_BIND][ST_IN_USE],
                 op_stat[OP_BIND][ST_FULL],
                 " unbinds ok/missing %0d/%0d",
                 op_stat[OP_UNBIND][ST_OK], op_stat[OP_UNBIND][ST_NOT_FOUND]);
        $display("Lookups hit/miss %0d/%0d, %0d undefined operation codes,",
                 op_stat[OP_LOOKUP][ST_OK], op_stat[OP_LOOKUP][ST_NOT_FOUND],
                 op_stat[OP_NONE][ST_OK], " one long receiver stall");
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: port_binding_table.f
sv/pbt_pkg.sv
sv/pbt_req_if.sv
sv/pbt_rsp_if.sv
sv/pbt_ram.sv
sv/pbt_ctrl.sv
sv/pbt_dp.sv
sv/port_binding_table.sv
sv/pbt_checker.sv
tb/sv/tb_port_binding_table.sv
